### rtl/core/lpd_pkg.sv
// Shared types and constants for the Legendre polynomial and derivative evaluator.
// Holds the fixed-point formats, the sequencer state and operation codes and the
// recurrence coefficient table. No dependencies.
`timescale 1ns / 1ps

package lpd_pkg;

	// field widths
	localparam int X_W   = 32;
	localparam int P_W   = 32;
	localparam int D_W   = 40;
	localparam int DEG_W = 5;

	// fixed-point format and degree limit
	localparam int FRAC_BITS = 30;
	localparam logic [DEG_W-1:0] MAX_DEGREE = 5'd16;

	// datapath widths
	localparam int MA_W   = 32;               // multiplier A magnitude
	localparam int MB_W   = 48;               // multiplier B magnitude
	localparam int HALF_W = MB_W / 2;         // B slice handled per cycle
	localparam int ACC_W  = MA_W + MB_W;      // full product
	localparam int Q_W    = ACC_W - FRAC_BITS; // scaled magnitude
	localparam int RES_W  = Q_W + 2;          // signed sum of base and scaled product
	localparam int S_W    = 49;               // clamped x*P' + P
	localparam int T_W    = 34;               // x*P
	localparam int R_W    = 50;               // a*t or a*s
	localparam int SUM_LIM_BITS = 47;

	localparam logic signed [P_W-1:0] ONE_P = P_W'(64'd1 << FRAC_BITS);
	localparam logic signed [D_W-1:0] ONE_D = D_W'(64'd1 << FRAC_BITS);
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_SETUP,
		ST_LO,
		ST_HI,
		ST_FIN
	} state_t;

	// products formed for one new degree, in issue order
	typedef enum logic [2:0] {
		OP_XP,  // t = x * P_k
		OP_XD,  // s = clamp(x * P'_k + P_k)
		OP_AT,  // r = a * t
		OP_BP,  // P_k+1 = sat(r - b * P_k-1)
		OP_AS,  // r = a * s
		OP_BD   // P'_k+1 = sat(r - b * P'_k-1)
	} op_t;

	typedef struct packed {
		logic [MA_W-1:0] a;
		logic [MA_W-1:0] b;
	} coef_t;

	// a_j = round((2j+1)/(j+1)), b_j = round(j/(j+1)), Q2.F, halves up
	function automatic coef_t coef_lookup(input logic [3:0] j);
		coef_t c;
		c = '0;
		case (j)
			4'd1: begin
				c.a = MA_W'(((64'd3 << FRAC_BITS) + 64'd1) / 64'd2);
				c.b = MA_W'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd2);
			end
			4'd2: begin
				c.a = MA_W'(((64'd5 << FRAC_BITS) + 64'd1) / 64'd3);
				c.b = MA_W'(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);
			end
			4'd3: begin
				c.a = MA_W'(((64'd7 << FRAC_BITS) + 64'd2) / 64'd4);
				c.b = MA_W'(((64'd3 << FRAC_BITS) + 64'd2) / 64'd4);
			end
			4'd4: begin
				c.a = MA_W'(((64'd9 << FRAC_BITS) + 64'd2) / 64'd5);
				c.b = MA_W'(((64'd4 << FRAC_BITS) + 64'd2) / 64'd5);
			end
			4'd5: begin
				c.a = MA_W'(((64'd11 << FRAC_BITS) + 64'd3) / 64'd6);
				c.b = MA_W'(((64'd5 << FRAC_BITS) + 64'd3) / 64'd6);
			end
			4'd6: begin
				c.a = MA_W'(((64'd13 << FRAC_BITS) + 64'd3) / 64'd7);
				c.b = MA_W'(((64'd6 << FRAC_BITS) + 64'd3) / 64'd7);
			end
			4'd7: begin
				c.a = MA_W'(((64'd15 << FRAC_BITS) + 64'd4) / 64'd8);
				c.b = MA_W'(((64'd7 << FRAC_BITS) + 64'd4) / 64'd8);
			end
			4'd8: begin
				c.a = MA_W'(((64'd17 << FRAC_BITS) + 64'd4) / 64'd9);
				c.b = MA_W'(((64'd8 << FRAC_BITS) + 64'd4) / 64'd9);
			end
			4'd9: begin
				c.a = MA_W'(((64'd19 << FRAC_BITS) + 64'd5) / 64'd10);
				c.b = MA_W'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);
			end
			4'd10: begin
				c.a = MA_W'(((64'd21 << FRAC_BITS) + 64'd5) / 64'd11);
				c.b = MA_W'(((64'd10 << FRAC_BITS) + 64'd5) / 64'd11);
			end
			4'd11: begin
				c.a = MA_W'(((64'd23 << FRAC_BITS) + 64'd6) / 64'd12);
				c.b = MA_W'(((64'd11 << FRAC_BITS) + 64'd6) / 64'd12);
			end
			4'd12: begin
				c.a = MA_W'(((64'd25 << FRAC_BITS) + 64'd6) / 64'd13);
				c.b = MA_W'(((64'd12 << FRAC_BITS) + 64'd6) / 64'd13);
			end
			4'd13: begin
				c.a = MA_W'(((64'd27 << FRAC_BITS) + 64'd7) / 64'd14);
				c.b = MA_W'(((64'd13 << FRAC_BITS) + 64'd7) / 64'd14);
			end
			4'd14: begin
				c.a = MA_W'(((64'd29 << FRAC_BITS) + 64'd7) / 64'd15);
				c.b = MA_W'(((64'd14 << FRAC_BITS) + 64'd7) / 64'd15);
			end
			4'd15: begin
				c.a = MA_W'(((64'd31 << FRAC_BITS) + 64'd8) / 64'd16);
				c.b = MA_W'(((64'd15 << FRAC_BITS) + 64'd8) / 64'd16);
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

endpackage

### rtl/core/lpd_if.sv
// Valid/ready channel interfaces for the evaluator's abscissa input and result output.
// Depends on lpd_pkg for the field widths.
`timescale 1ns / 1ps

interface lpd_in_if import lpd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

interface lpd_out_if import lpd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [DEG_W-1:0]      degree_index;
	logic signed [P_W-1:0] poly_value;
	logic signed [D_W-1:0] deriv_value;
	logic                  last;

	modport source (output valid, output degree_index, output poly_value,
		output deriv_value, output last, input ready);
	modport sink (input valid, input degree_index, input poly_value,
		input deriv_value, input last, output ready);
endinterface

### rtl/core/legendre_poly_and_derivative_eval_core.sv
// Legendre polynomial and derivative evaluator: top level, sequencer and shared multiplier.
// Depends on lpd_pkg and the channel interfaces in lpd_if.sv.
`timescale 1ns / 1ps

// Each abscissa taken on in_ch yields P_k(x) and P'_k(x) for k = 0 up to the
// degree register (clamped to 16), one transfer per degree on out_ch, ascending,
// with last set on the final one. Degrees 0 and 1 are seeds; every higher degree
// runs six products one after another through a single 32x24 multiplier, each
// with an operand setup step (ST_SETUP), low and high slice multiply steps
// (ST_LO, ST_HI, rounding added on the low slice) and a step that restores the
// sign and folds in the add or subtract (ST_FIN), and then hands off its result
// in ST_EMIT, which waits while the output register is full and not taken.
// in_ch is ready again in the cycle after the last result of an item is loaded
// into the output register. in_ch is ready only between items; the last result
// may still wait in the output register when the next abscissa is taken.
// The degree register is written through cfg_wr_en/cfg_wr_data; the user is to
// write it only between items, as the block itself does not enforce this.
module legendre_poly_and_derivative_eval_core
	import lpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [DEG_W-1:0] cfg_wr_data,
	lpd_in_if.sink           in_ch,
	lpd_out_if.source        out_ch
);

	// saturate a wide signed value to the polynomial format
	function automatic logic signed [P_W-1:0] sat_p(input logic signed [RES_W-1:0] v);
		logic signed [P_W-1:0] r;
		if (v[RES_W-1:P_W-1] == '0 || v[RES_W-1:P_W-1] == '1) begin
			r = v[P_W-1:0];
		end else if (v[RES_W-1]) begin
			r = {1'b1, {(P_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(P_W-1){1'b1}}};
		end
		return r;
	endfunction

	// saturate a wide signed value to the derivative format
	function automatic logic signed [D_W-1:0] sat_d(input logic signed [RES_W-1:0] v);
		logic signed [D_W-1:0] r;
		if (v[RES_W-1:D_W-1] == '0 || v[RES_W-1:D_W-1] == '1) begin
			r = v[D_W-1:0];
		end else if (v[RES_W-1]) begin
			r = {1'b1, {(D_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(D_W-1){1'b1}}};
		end
		return r;
	endfunction

	localparam logic signed [RES_W-1:0] S_LIM = RES_W'(64'd1 << SUM_LIM_BITS);

	// control
	state_t           state_q, state_d;
	op_t              op_q;
	logic [DEG_W-1:0] degree_q;
	logic [DEG_W-1:0] deg_q;
	logic [DEG_W-1:0] k_q;
	logic             out_valid_q;
	logic             in_xfer;
	logic             load_out;
	logic             is_last;

	// recurrence state
	logic signed [X_W-1:0] x_q;
	logic signed [P_W-1:0] pc_q, pp_q, nv_q;
	logic signed [D_W-1:0] dc_q, dp_q;
	logic signed [T_W-1:0] t_q;
	logic signed [S_W-1:0] s_q;
	logic signed [R_W-1:0] r_q;

	// shared multiplier
	logic [MA_W-1:0]          ma_q;
	logic [MB_W-1:0]          mb_q;
	logic                     neg_q;
	logic [ACC_W-1:0]         acc_q;
	logic [HALF_W-1:0]        mul_b;
	logic [MA_W+HALF_W-1:0]   prod;

	// output register
	logic [DEG_W-1:0]      oidx_q;
	logic signed [P_W-1:0] opoly_q;
	logic signed [D_W-1:0] oderiv_q;
	logic                  olast_q;

	// operand selection and result combine
	coef_t                   coef;
	logic signed [MA_W:0]    a_sel, a_abs;
	logic signed [S_W-1:0]   b_sel, b_abs;
	logic [Q_W-1:0]          q_mag;
	logic signed [RES_W-1:0] q_ext, base, res;
	logic                    flip;
	logic [DEG_W-1:0]        deg_eff;

	assign is_last = (k_q == deg_q);
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign deg_eff = (degree_q > MAX_DEGREE) ? MAX_DEGREE : degree_q;

	// advance the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_out) begin
					if (is_last) state_d = ST_IDLE;
					else if (k_q == '0) state_d = ST_EMIT;
					else state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_LO;
			ST_LO:    state_d = ST_HI;
			ST_HI:    state_d = ST_FIN;
			ST_FIN: begin
				state_d = (op_q == OP_BD) ? ST_EMIT : ST_SETUP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		load_out    = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_XP;
			degree_q    <= 5'd16;
			deg_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) degree_q <= cfg_wr_data;
			if (in_xfer) begin
				deg_q <= deg_eff;
				k_q   <= '0;
			end
			if (load_out && !is_last) begin
				k_q  <= k_q + 5'd1;
				op_q <= OP_XP;
			end
			if (state_q == ST_FIN && op_q != OP_BD) op_q <= op_t'(op_q + 3'd1);
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// pick operands for the next product
	assign coef = coef_lookup(4'(k_q - 5'd1));

	always_comb begin
		case (op_q)
			OP_XP, OP_XD: a_sel = (MA_W+1)'(x_q);
			OP_AT, OP_AS: a_sel = {1'b0, coef.a};
			default:      a_sel = {1'b0, coef.b};
		endcase
		case (op_q)
			OP_XP:   b_sel = S_W'(pc_q);
			OP_XD:   b_sel = S_W'(dc_q);
			OP_AT:   b_sel = S_W'(t_q);
			OP_BP:   b_sel = S_W'(pp_q);
			OP_AS:   b_sel = s_q;
			default: b_sel = S_W'(dp_q);
		endcase
		a_abs = a_sel[MA_W] ? -a_sel : a_sel;
		b_abs = b_sel[S_W-1] ? -b_sel : b_sel;
	end

	// one multiplier, B magnitude fed in two slices
	assign mul_b = (state_q == ST_HI) ? mb_q[MB_W-1:HALF_W] : mb_q[HALF_W-1:0];
	assign prod  = ma_q * mul_b;

	// round the magnitude, restore the sign and fold in the add or subtract;
	// the product stays below 2^80, so the scaled magnitude never reaches 2^50
	assign q_mag = acc_q[ACC_W-1:FRAC_BITS];
	assign q_ext = {2'b00, q_mag};

	always_comb begin
		case (op_q)
			OP_XD:        base = RES_W'(pc_q);
			OP_BP, OP_BD: base = RES_W'(r_q);
			default:      base = '0;
		endcase
		flip = neg_q ^ ((op_q == OP_BP) || (op_q == OP_BD));
		res  = flip ? (base - q_ext) : (base + q_ext);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					x_q  <= in_ch.x_value;
					pp_q <= '0;
					dp_q <= '0;
					pc_q <= ONE_P;
					dc_q <= '0;
				end
			end
			ST_EMIT: begin
				// seed degree one
				if (load_out && !is_last && k_q == '0) begin
					pp_q <= pc_q;
					dp_q <= dc_q;
					pc_q <= x_q;
					dc_q <= ONE_D;
				end
			end
			ST_SETUP: begin
				ma_q  <= a_abs[MA_W-1:0];
				mb_q  <= b_abs[MB_W-1:0];
				neg_q <= a_sel[MA_W] ^ b_sel[S_W-1];
			end
			ST_LO: begin
				acc_q <= ACC_W'(prod) + ROUND_HALF;
			end
			ST_HI: begin
				acc_q <= acc_q + (ACC_W'(prod) << HALF_W);
			end
			ST_FIN: begin
				case (op_q)
					OP_XP: t_q <= res[T_W-1:0];
					OP_XD: begin
						if (res > S_LIM) s_q <= S_LIM[S_W-1:0];
						else if (res < -S_LIM) s_q <= S_W'(-S_LIM);
						else s_q <= res[S_W-1:0];
					end
					OP_AT, OP_AS: r_q <= res[R_W-1:0];
					OP_BP: nv_q <= sat_p(res);
					OP_BD: begin
						pp_q <= pc_q;
						dp_q <= dc_q;
						pc_q <= nv_q;
						dc_q <= sat_d(res);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// hold the result until the transfer
	always_ff @(posedge clk) begin
		if (load_out) begin
			oidx_q   <= k_q;
			opoly_q  <= pc_q;
			oderiv_q <= dc_q;
			olast_q  <= is_last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.degree_index = oidx_q;
	assign out_ch.poly_value   = opoly_q;
	assign out_ch.deriv_value  = oderiv_q;
	assign out_ch.last         = olast_q;

	// checks
	a_deg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		deg_q <= MAX_DEGREE)
		else $error("latched degree above limit");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> k_q <= deg_q)
		else $error("degree counter ran past the latched degree");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && is_last |=> state_q == ST_IDLE && out_valid_q && out_ch.last)
		else $error("final result did not end the item");

	a_take_seed: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_EMIT && k_q == '0)
		else $error("abscissa transfer did not start at degree zero");

	a_fin_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && op_q == OP_BD |=> state_q == ST_EMIT)
		else $error("degree update did not hand off a result");

endmodule
